@@ rtl/printable_line_assembler_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the printable line assembler
// Shared concurrent-check forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef PRINTABLE_LINE_ASSEMBLER_ASSERT_SVH
`define PRINTABLE_LINE_ASSEMBLER_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define PLA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define PLA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define PLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pla_pkg.sv @@
// ---------------------------------------------------------------------------
// pla_pkg
// Types and character constants shared by the line assembler modules.
// ---------------------------------------------------------------------------
package pla_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned POS_W  = 6;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

  typedef logic [CHAR_W-1:0] char_t;

  // Per-cycle command broadcast along the cell row.
  typedef struct packed {
    logic  shift;    // take the neighbour's character
    logic  append;   // a new character is being stored this cycle
    char_t wr_char;  // the character being stored
  } cell_cmd_t;

endpackage

@@ rtl/pla_cell.sv @@
// ---------------------------------------------------------------------------
// pla_cell
// One character cell of the line row: load on append, pass on replay.
// ---------------------------------------------------------------------------
module pla_cell (
  input  logic              clk,
  input  pla_pkg::cell_cmd_t cmd,
  input  logic              sel,       // this cell is the append slot
  input  pla_pkg::char_t    nbr_char,  // character of the next cell up
  output pla_pkg::char_t    char_q
);

  pla_pkg::char_t char_r;
  pla_pkg::char_t char_nxt;

  always_comb begin
    char_nxt = char_r;
    if (cmd.shift) begin
      char_nxt = nbr_char;
    end else if (cmd.append && sel) begin
      char_nxt = cmd.wr_char;
    end
  end

  // Payload only: no reset.
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_q = char_r;

endmodule

@@ rtl/printable_line_assembler.sv @@
// ---------------------------------------------------------------------------
// printable_line_assembler
// Builds text lines from serial bytes in a row of character cells and
// replays each finished line one character per beat.
// ---------------------------------------------------------------------------
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   in_      | input     | in_valid/in_stall  | in_rx_byte[7:0]
//   out_     | output    | out_valid/out_stall| char_code, char_position,
//            |           |                    | line_length, is_last
//   cfg_     | input     | cfg_valid/cfg_ready| cfg_sink_enable
//
// Input: one byte per cycle while in_stall is low. A line feed that releases a line
//   holds in_stall high while the cell row drains through cell 0, one character
//   per cycle into the single output register while that register is free.
// Output stalls hold the output register and pause the drain; the input side
//   keeps taking bytes while a final character waits to be taken.
// Reset (rst_n low, synchronous) empties the line and sets sink_enable to 1;
//   cell contents are left as they are, and no clearing pass is needed.
// cfg_ready is always high.
// ---------------------------------------------------------------------------
module printable_line_assembler #(
  parameter int unsigned LINE_CAPACITY = 40
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char_code,
  output logic [5:0] out_char_position,
  output logic [5:0] out_line_length,
  output logic       out_is_last,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_sink_enable
);

  `include "printable_line_assembler_assert.svh"

  // Characters held at most; the count must reach DEPTH itself.
  localparam int unsigned DEPTH = LINE_CAPACITY - 1;
  localparam int unsigned CNT_W = $clog2(LINE_CAPACITY);

  typedef enum logic {
    ST_COLLECT,
    ST_REPLAY
  } state_t;

  state_t                 state_r,   state_nxt;
  logic [CNT_W-1:0]       count_r,   count_nxt;
  logic [CNT_W-1:0]       len_r,     len_nxt;
  logic [CNT_W-1:0]       pos_r,     pos_nxt;
  logic                   sink_en_r, sink_en_nxt;

  logic                   out_valid_r,   out_valid_nxt;
  pla_pkg::char_t         out_code_r,    out_code_nxt;
  logic [CNT_W-1:0]       out_pos_r,     out_pos_nxt;
  logic [CNT_W-1:0]       out_len_r,     out_len_nxt;
  logic                   out_last_r,    out_last_nxt;

  logic                   in_beat;
  logic                   is_cr;
  logic                   is_lf;
  logic                   is_print;
  logic                   has_room;
  logic                   do_append;
  logic                   start_replay;
  logic                   out_load;
  logic                   pos_is_last;

  pla_pkg::cell_cmd_t     cmd;
  pla_pkg::char_t         cell_q [DEPTH];

  // -------------------------------------------------------------------------
  // Byte decode
  // -------------------------------------------------------------------------
  assign in_stall  = (state_r == ST_REPLAY);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign is_cr    = (in_rx_byte == pla_pkg::CH_CR);
  assign is_lf    = (in_rx_byte == pla_pkg::CH_LF);
  assign is_print = (in_rx_byte >= pla_pkg::PRINT_LO) && (in_rx_byte <= pla_pkg::PRINT_HI);
  assign has_room = (count_r < CNT_W'(DEPTH));

  assign do_append    = in_beat && is_print && has_room;
  assign start_replay = in_beat && is_lf && (count_r != '0) && sink_en_r;

  // Drain one cell into the output register whenever that register is free.
  assign out_load    = (state_r == ST_REPLAY) && (!out_valid_r || !out_stall);
  assign pos_is_last = (pos_r == (len_r - CNT_W'(1)));

  assign cmd.shift   = out_load;
  assign cmd.append  = do_append;
  assign cmd.wr_char = in_rx_byte[pla_pkg::CHAR_W-1:0];

  // -------------------------------------------------------------------------
  // Cell row: cell 0 faces the output, the top cell takes zeros on a shift
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pla_pkg::char_t nbr;
    if (i == DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    pla_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .sel      (count_r == CNT_W'(i)),
      .nbr_char (nbr),
      .char_q   (cell_q[i])
    );
  end

  // -------------------------------------------------------------------------
  // Next-state logic
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    sink_en_nxt   = sink_en_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_pos_nxt   = out_pos_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid && cfg_ready) begin
      sink_en_nxt = cfg_sink_enable;
    end

    // Line bookkeeping: carriage return is a no-op, anything else that
    // cannot be appended drops the partial line.
    if (in_beat && !is_cr) begin
      if (do_append) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        count_nxt = '0;
      end
    end

    if (start_replay) begin
      state_nxt = ST_REPLAY;
      len_nxt   = count_r;
      pos_nxt   = '0;
    end

    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = cell_q[0];
      out_pos_nxt   = pos_r;
      out_len_nxt   = len_r;
      out_last_nxt  = pos_is_last;
      pos_nxt       = pos_r + CNT_W'(1);
      if (pos_is_last) begin
        state_nxt = ST_COLLECT;
      end
    end
  end

  // -------------------------------------------------------------------------
  // State and registered outputs
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      sink_en_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sink_en_r   <= sink_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r      <= len_nxt;
    pos_r      <= pos_nxt;
    out_code_r <= out_code_nxt;
    out_pos_r  <= out_pos_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_char_code     = out_code_r;
  assign out_char_position = pla_pkg::POS_W'(out_pos_r);
  assign out_line_length   = pla_pkg::POS_W'(out_len_r);
  assign out_is_last       = out_last_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `PLA_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "held count beyond line depth")
  `PLA_ASSERT_IMPL(a_out_pos_in_line, out_valid_r, out_pos_r < out_len_r, "position past length")
  `PLA_ASSERT_IMPL(a_out_last_match, out_valid_r, out_last_r == (out_pos_r == (out_len_r - CNT_W'(1))), "last flag mismatch")
  `PLA_ASSERT_NEXT(a_replay_clears, start_replay, count_r == '0 && state_r == ST_REPLAY, "line not cleared on replay")
  `PLA_ASSERT_IMPL(a_replay_len_ok, state_r == ST_REPLAY, len_r != '0 && pos_r < len_r, "replay beyond line")

endmodule

@@ tb/printable_line_assembler_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// printable_line_assembler_tb
// Self-checking bench: serial bytes go in, completed lines come back one
// character beat at a time and are compared with a line predictor kept in
// step with every accepted byte.
// ---------------------------------------------------------------------------
module printable_line_assembler_tb;

  localparam int unsigned LINE_CAPACITY = 40;
  localparam int unsigned STORE_DEPTH   = LINE_CAPACITY - 1;
  // A released line stalls the input while it drains; this wait is longer than
  // STORE_DEPTH, the deepest line, with room to spare.
  localparam int unsigned DRAIN_WAIT    = 48;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned N_DIRECTED    = 26;

  // One character beat of a completed line.
  typedef struct packed {
    pla_pkg::char_t            code;
    logic [pla_pkg::POS_W-1:0] pos;
    logic [pla_pkg::POS_W-1:0] len;
    logic                      last;
  } line_char_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // Directed stimulus row. A "typed" row carries its own expectation: either
  // nothing, or a single-character line (position 0, length 1, last).
  typedef struct packed {
    row_kind_t                  kind;
    logic [pla_pkg::BYTE_W-1:0] value;
    logic                       typed;
    logic                       has_char;
    pla_pkg::char_t             code;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  logic [pla_pkg::BYTE_W-1:0] in_rx_byte      = '0;
  logic                       out_valid;
  logic                       out_stall       = 1'b0;
  logic [6:0]                 out_char_code;
  logic [5:0]                 out_char_position;
  logic [5:0]                 out_line_length;
  logic                       out_is_last;
  logic                       cfg_valid       = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_sink_enable = 1'b0;

  // Predictor state: the line being built and the sink switch.
  pla_pkg::char_t line_buf [STORE_DEPTH];
  int unsigned    held_len = 0;
  logic           sink_on  = 1'b1;
  line_char_t     chars_due [$];

  int unsigned  mismatch_count = 0;
  int unsigned  items_sent     = 0;
  int unsigned  burst_left     = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  stall_mode     = 0;
  int unsigned  stall_span     = 0;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_BYTE, pla_pkg::CH_LF,    1'b1, 1'b0, 7'h00}, // line feed on an empty line
    '{ROW_BYTE, pla_pkg::CH_CR,    1'b1, 1'b0, 7'h00}, // carriage return alone
    '{ROW_BYTE, pla_pkg::PRINT_LO, 1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, pla_pkg::CH_LF,    1'b1, 1'b1, 7'h20}, // lowest printable
    '{ROW_BYTE, pla_pkg::PRINT_HI, 1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, pla_pkg::CH_LF,    1'b1, 1'b1, 7'h7E}, // highest printable
    '{ROW_BYTE, 8'h41,             1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, pla_pkg::CH_CR,    1'b0, 1'b0, 7'h00}, // CR mid-line is skipped
    '{ROW_BYTE, 8'h42,             1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, pla_pkg::CH_LF,    1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, 8'h78,             1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, 8'h00,             1'b0, 1'b0, 7'h00}, // control byte drops the line
    '{ROW_BYTE, pla_pkg::CH_LF,    1'b1, 1'b0, 7'h00},
    '{ROW_BYTE, 8'h79,             1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, 8'hFF,             1'b0, 1'b0, 7'h00}, // top-bit byte drops the line
    '{ROW_BYTE, pla_pkg::CH_LF,    1'b1, 1'b0, 7'h00},
    '{ROW_BYTE, 8'h7A,             1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, 8'h7F,             1'b0, 1'b0, 7'h00}, // just above the printable range
    '{ROW_BYTE, 8'h1F,             1'b0, 1'b0, 7'h00}, // just below it
    '{ROW_BYTE, pla_pkg::CH_LF,    1'b1, 1'b0, 7'h00},
    '{ROW_CFG,  8'h00,             1'b0, 1'b0, 7'h00}, // sink off
    '{ROW_BYTE, 8'h71,             1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, pla_pkg::CH_LF,    1'b1, 1'b0, 7'h00}, // line dropped, not emitted
    '{ROW_CFG,  8'h01,             1'b0, 1'b0, 7'h00}, // sink back on
    '{ROW_BYTE, 8'h72,             1'b0, 1'b0, 7'h00},
    '{ROW_BYTE, pla_pkg::CH_LF,    1'b1, 1'b1, 7'h72}  // only the fresh character
  };

  printable_line_assembler #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_code    (out_char_code),
    .out_char_position(out_char_position),
    .out_line_length  (out_line_length),
    .out_is_last      (out_is_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_sink_enable  (cfg_sink_enable)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance the line predictor by one accepted byte. With keep low the state
  // still moves, but any released characters are not queued: the caller
  // supplies its own expectation instead.
  task automatic assemble_byte(input logic [pla_pkg::BYTE_W-1:0] b, input logic keep);
    line_char_t  c;
    int unsigned k;
    if (b == pla_pkg::CH_CR) begin
      // ignored entirely
    end else if (b == pla_pkg::CH_LF) begin
      if (held_len != 0 && sink_on && keep) begin
        for (k = 0; k < held_len; k++) begin
          c.code = line_buf[k];
          c.pos  = pla_pkg::POS_W'(k);
          c.len  = pla_pkg::POS_W'(held_len);
          c.last = (k + 1 == held_len);
          chars_due.push_back(c);
        end
      end
      held_len = 0;
    end else if (b >= pla_pkg::PRINT_LO && b <= pla_pkg::PRINT_HI &&
                 held_len + 1 < LINE_CAPACITY) begin
      line_buf[held_len] = b[pla_pkg::CHAR_W-1:0];
      held_len++;
    end else begin
      // control byte, top-bit byte, or a printable arriving at a full line
      held_len = 0;
    end
  endtask

  // Present one byte and hold it until the block takes it. The sender runs
  // in bursts; between bursts it may drop valid for a random gap.
  task automatic send_byte(input logic [pla_pkg::BYTE_W-1:0] b, input logic keep);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
      gap = $urandom_range(1, 6);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    assemble_byte(b, keep);
  endtask

  // Printable characters, with the odd CR thrown in, closed by a line feed.
  task automatic send_line(input int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      send_byte(pla_pkg::BYTE_W'($urandom_range(pla_pkg::PRINT_LO, pla_pkg::PRINT_HI)), 1'b1);
      if ($urandom_range(0, 11) == 0) send_byte(pla_pkg::CH_CR, 1'b1);
    end
    send_byte(pla_pkg::CH_LF, 1'b1);
  endtask

  // Drop valid and hold off until every character due has been taken, then
  // give the block time to finish any line it may still be draining.
  task automatic settle_line();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_sink(input logic v);
    cfg_valid       <= 1'b1;
    cfg_sink_enable <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sink_on    = v;
  endtask

  // One random stretch of input: mostly well-formed lines, some long ones,
  // broken lines, stray bytes, and now and then a full drain before going on.
  task automatic send_random_stretch();
    int unsigned                pick;
    int unsigned                k;
    logic [pla_pkg::BYTE_W-1:0] bad;
    pick = $urandom_range(0, 19);
    if (pick <= 12) begin
      send_line($urandom_range(1, 8));
    end else if (pick <= 14) begin
      send_line($urandom_range(9, STORE_DEPTH));
    end else if (pick == 15) begin
      for (k = $urandom_range(1, 6); k != 0; k--)
        send_byte(pla_pkg::BYTE_W'($urandom_range(pla_pkg::PRINT_LO, pla_pkg::PRINT_HI)),
                  1'b1);
      do bad = pla_pkg::BYTE_W'($urandom_range(0, 255));
      while ((bad >= pla_pkg::PRINT_LO && bad <= pla_pkg::PRINT_HI) ||
             bad == pla_pkg::CH_CR || bad == pla_pkg::CH_LF);
      send_byte(bad, 1'b1);
      send_line($urandom_range(0, 4));
    end else if (pick <= 17) begin
      send_byte(pla_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
    end else if (pick == 18) begin
      send_byte($urandom_range(0, 1) ? pla_pkg::CH_LF : pla_pkg::CH_CR, 1'b1);
    end else begin
      // hold the sender until the output side has caught up completely
      in_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clk); while (chars_due.size() != 0);
      send_line($urandom_range(1, 6));
    end
  endtask

  // Receiver stall pattern: switch between no stalls, light random stalls,
  // heavy random stalls and a square wave, each for a random span.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(8, 64);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_span[1];
    endcase
  end

  // Check every character beat taken against the oldest one due.
  always @(posedge clk) begin : take_char
    line_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (chars_due.size() == 0) begin
        $error("character beat with none due: char_code %0h position %0d",
               out_char_code, out_char_position);
        mismatch_count++;
      end else begin
        want = chars_due.pop_front();
        if (out_char_code !== want.code) begin
          $error("char_code: expected %0h, got %0h", want.code, out_char_code);
          mismatch_count++;
        end
        if (out_char_position !== want.pos) begin
          $error("char_position: expected %0d, got %0d", want.pos, out_char_position);
          mismatch_count++;
        end
        if (out_line_length !== want.len) begin
          $error("line_length: expected %0d, got %0d", want.len, out_line_length);
          mismatch_count++;
        end
        if (out_is_last !== want.last) begin
          $error("is_last: expected %0b, got %0b", want.last, out_is_last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** printable_line_assembler: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int          ph;
    int unsigned first_item;
    int unsigned phase_items [3];
    // The directed rows and the full-line checks already take most of the
    // item budget, so the random phases stay short.
    phase_items = '{6, 3, 6};

    // Hold reset from the start, then release it on a clock edge.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed rows bring their own expectation, the rest are
    // left to the predictor.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle_line();
        write_sink(directed_rows[i].value[0]);
      end else begin
        send_byte(directed_rows[i].value, !directed_rows[i].typed);
        if (directed_rows[i].typed && directed_rows[i].has_char)
          chars_due.push_back(line_char_t'{directed_rows[i].code, 6'd0, 6'd1, 1'b1});
      end
    end

    // Random phases: sink on, sink off, sink on again.
    for (ph = 0; ph < 3; ph++) begin
      settle_line();
      write_sink(ph != 1);
      if (ph == 0) begin
        // Fill the line exactly, then overfill it: the extra printable drops
        // the whole line and only what follows it is released.
        send_line(STORE_DEPTH);
        for (int k = 0; k < STORE_DEPTH + 1; k++)
          send_byte(pla_pkg::BYTE_W'($urandom_range(pla_pkg::PRINT_LO, pla_pkg::PRINT_HI)),
                    1'b1);
        send_line($urandom_range(1, 5));
      end
      first_item = items_sent;
      while (items_sent - first_item < phase_items[ph]) send_random_stretch();
    end

    settle_line();
    if (mismatch_count == 0) begin
      $display("** printable_line_assembler: PASSED **");
    end else begin
      $display("** printable_line_assembler: FAILED **");
    end
    $finish;
  end

endmodule

@@ printable_line_assembler.f @@
+incdir+rtl
rtl/pla_pkg.sv
rtl/pla_cell.sv
rtl/printable_line_assembler.sv
tb/printable_line_assembler_tb.sv
